// ===== hw/rtl/ber_tlv_tag_finder_defines.svh =====
// Assertion macros for the BER-TLV tag finder checker.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef BER_TLV_TAG_FINDER_DEFINES_SVH
`define BER_TLV_TAG_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BTLV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btlv check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BTLV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btlv check failed");

`endif

// ===== hw/rtl/btlv_pkg.sv =====
// Shared types and constants of the BER-TLV tag finder.
// No dependencies; imported by the parser, the output queue, the top level, the checker and the testbench.
package btlv_pkg;

  // Record kinds
  localparam logic KindHeader = 1'b0;
  localparam logic KindEnd    = 1'b1;

  // Header byte codes
  localparam logic [4:0] TagExtMask = 5'h1f;
  localparam logic [7:0] LenOneByte = 8'h81;
  localparam logic [7:0] LenTwoByte = 8'h82;

  // Output queue geometry
  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic        kind;
    logic [15:0] tag;
    logic [15:0] value_len;
    logic [15:0] value_offset;
    logic        tag_match;
    logic        found;
    logic        truncated;
    logic        last_of_run;
  } rec_t;

  // Records produced by one byte: first and, on a header plus end, second.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== hw/rtl/ber_tlv_tag_finder.sv =====
// BER-TLV tag finder top level: config register, header walker, result queue.
// Depends on btlv_pkg, btlv_parser and btlv_outq.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one buffer byte per
//   transfer with last_byte_i marking the final byte of a buffer.
//   Output channel (out_valid_o / out_stall_i) carries records: a header
//   record for every completed tag+length header, and an end record after
//   the last byte holding found, first match offset/length and truncated.
//   A byte that closes a header and is also the last yields two records,
//   header first; last_of_run_o flags the final record of each byte.
//   A record enters the result queue register when its byte transfers and is shown once it reaches the head.
//   Throughput: one byte per cycle; the limit is the four-entry result
//   queue, which stalls input once it holds more than two records. Output
//   drains one record per cycle while out_stall_i is low.
//   A stalled receiver holds the head record; the queue keeps taking bytes
//   until its room for a two-record byte is gone.
//   cfg_we_i/cfg_wdata_i write target_tag; write it only while idle.
//   Reset clears the walk state, the target tag and the queue.
module ber_tlv_tag_finder import btlv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [15:0] tag_o,
  output logic [15:0] value_len_o,
  output logic [15:0] value_offset_o,
  output logic        tag_match_o,
  output logic        found_o,
  output logic        truncated_o,
  output logic        last_of_run_o
);

  logic [15:0] target_q;
  logic        room;
  logic        fire;
  push_t       push;
  rec_t        rec0;
  rec_t        rec1;
  rec_t        head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 16'd0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !room;
  assign fire       = in_valid_i && room;

  btlv_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .target_tag_i (target_q),
    .push_o       (push),
    .rec0_o       (rec0),
    .rec1_o       (rec1)
  );

  btlv_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec0_i      (rec0),
    .rec1_i      (rec1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign record_kind_o  = head.kind;
  assign tag_o          = head.tag;
  assign value_len_o    = head.value_len;
  assign value_offset_o = head.value_offset;
  assign tag_match_o    = head.tag_match;
  assign found_o        = head.found;
  assign truncated_o    = head.truncated;
  assign last_of_run_o  = head.last_of_run;

endmodule

// ===== hw/rtl/btlv_parser.sv =====
// Byte-wise BER-TLV header walker: phase, tag/length build, offsets, match.
// Depends on btlv_pkg; emits up to two records per accepted byte.
module btlv_parser import btlv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] target_tag_i,
  output push_t       push_o,
  output rec_t        rec0_o,
  output rec_t        rec1_o
);

  localparam logic [2:0] PhTag0  = 3'd0;
  localparam logic [2:0] PhTag1  = 3'd1;
  localparam logic [2:0] PhLen0  = 3'd2;
  localparam logic [2:0] PhLen81 = 3'd3;
  localparam logic [2:0] PhLenHi = 3'd4;
  localparam logic [2:0] PhLenLo = 3'd5;
  localparam logic [2:0] PhSkip  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] tag_q, tag_d;
  logic [15:0] len_q, len_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] off_q, off_d;
  logic        seen_q, seen_d;
  logic [15:0] moff_q, moff_d;
  logic [15:0] mlen_q, mlen_d;

  logic        hdr_done;
  logic        hit;
  logic        trunc;
  logic [15:0] voff;
  logic [15:0] skip_dec;
  rec_t        hdr_rec;
  rec_t        end_rec;

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    len_d    = len_q;
    skip_d   = skip_q;
    seen_d   = seen_q;
    moff_d   = moff_q;
    mlen_d   = mlen_q;
    hdr_done = 1'b0;
    hit      = 1'b0;
    trunc    = 1'b0;
    voff     = off_q + 16'd1;
    skip_dec = skip_q - {15'd0, (skip_q != 16'd0)};

    case (phase_q)
      PhTag0: begin
        tag_d   = {8'd0, data_byte_i};
        phase_d = (data_byte_i[4:0] == TagExtMask) ? PhTag1 : PhLen0;
      end
      PhTag1: begin
        tag_d   = {tag_q[7:0], data_byte_i};
        phase_d = PhLen0;
      end
      PhLen0: begin
        if (data_byte_i == LenTwoByte) begin
          phase_d = PhLenHi;
        end else if (data_byte_i == LenOneByte) begin
          phase_d = PhLen81;
        end else begin
          len_d    = {8'd0, data_byte_i};
          hdr_done = 1'b1;
        end
      end
      PhLen81: begin
        len_d    = {8'd0, data_byte_i};
        hdr_done = 1'b1;
      end
      PhLenHi: begin
        len_d   = {data_byte_i, 8'd0};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d    = len_q | {8'd0, data_byte_i};
        hdr_done = 1'b1;
      end
      PhSkip: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = PhTag0;
        end
      end
      default: begin
        phase_d = PhTag0;
      end
    endcase

    if (hdr_done) begin
      hit = !seen_q && (tag_d == target_tag_i);
      if (hit) begin
        seen_d = 1'b1;
        moff_d = voff;
        mlen_d = len_d;
      end
      skip_d  = len_d;
      phase_d = (len_d == 16'd0) ? PhTag0 : PhSkip;
    end

    off_d = off_q + 16'd1;

    hdr_rec.kind         = KindHeader;
    hdr_rec.tag          = tag_d;
    hdr_rec.value_len    = len_d;
    hdr_rec.value_offset = voff;
    hdr_rec.tag_match    = hit;
    hdr_rec.found        = 1'b0;
    hdr_rec.truncated    = 1'b0;
    hdr_rec.last_of_run  = !last_byte_i;

    trunc = phase_d inside {[PhTag1:PhLenLo]};

    end_rec.kind         = KindEnd;
    end_rec.tag          = 16'd0;
    end_rec.value_len    = seen_d ? mlen_d : 16'd0;
    end_rec.value_offset = seen_d ? moff_d : 16'd0;
    end_rec.tag_match    = 1'b0;
    end_rec.found        = seen_d;
    end_rec.truncated    = trunc;
    end_rec.last_of_run  = 1'b1;

    // End of buffer: drop the walk state back to its reset values
    if (last_byte_i) begin
      phase_d = PhTag0;
      tag_d   = 16'd0;
      len_d   = 16'd0;
      skip_d  = 16'd0;
      off_d   = 16'd0;
      seen_d  = 1'b0;
      moff_d  = 16'd0;
      mlen_d  = 16'd0;
    end
  end

  assign push_o.first  = fire_i && (hdr_done || last_byte_i);
  assign push_o.second = fire_i && hdr_done && last_byte_i;
  assign rec0_o        = hdr_done ? hdr_rec : end_rec;
  assign rec1_o        = end_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag0;
      tag_q   <= 16'd0;
      len_q   <= 16'd0;
      skip_q  <= 16'd0;
      off_q   <= 16'd0;
      seen_q  <= 1'b0;
      moff_q  <= 16'd0;
      mlen_q  <= 16'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      off_q   <= off_d;
      seen_q  <= seen_d;
      moff_q  <= moff_d;
      mlen_q  <= mlen_d;
    end
  end

endmodule

// ===== hw/rtl/btlv_outq.sv =====
// Small shifting result queue: takes up to two records a cycle, shows the head.
// Depends on btlv_pkg for the record type and queue geometry.
module btlv_outq import btlv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  rec_t  rec0_i,
  input  rec_t  rec1_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output rec_t  head_o
);

  rec_t             q_q [QDepth];
  rec_t             q_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] cnt_pop;
  logic [QIdxW-1:0] wr0;
  logic [QIdxW-1:0] wr1;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = q_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // Room for a byte that may yield two records
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));

  always_comb begin
    cnt_pop = cnt_q - {{(QCntW-1){1'b0}}, pop};
    wr0     = cnt_pop[QIdxW-1:0];
    wr1     = wr0 + 1'b1;
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        q_d[i] = q_q[(i + 1) % QDepth];
      end else begin
        q_d[i] = q_q[i];
      end
      if (push_i.first && (wr0 == QIdxW'(i))) begin
        q_d[i] = rec0_i;
      end
      if (push_i.second && (wr1 == QIdxW'(i))) begin
        q_d[i] = rec1_i;
      end
    end
    cnt_d = cnt_pop + {{(QCntW-1){1'b0}}, push_i.first}
                    + {{(QCntW-1){1'b0}}, push_i.second};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

endmodule

// ===== hw/rtl/btlv_chk.sv =====
// Port-level checker for the BER-TLV tag finder, bound to the top level.
// Depends on btlv_pkg and ber_tlv_tag_finder_defines.svh.
`include "ber_tlv_tag_finder_defines.svh"
module btlv_chk import btlv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        record_kind_i,
  input logic [15:0] tag_i,
  input logic [15:0] value_len_i,
  input logic [15:0] value_offset_i,
  input logic        tag_match_i,
  input logic        found_i,
  input logic        truncated_i,
  input logic        last_of_run_i
);

  `BTLV_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i,
    out_valid_i && $stable(record_kind_i) && $stable(tag_i) && $stable(value_len_i)
    && $stable(value_offset_i) && $stable(last_of_run_i))

  `BTLV_ASSERT_NOW(a_end_shape, out_valid_i && (record_kind_i == KindEnd),
    (tag_i == 16'd0) && !tag_match_i && last_of_run_i)

  `BTLV_ASSERT_NOW(a_hdr_shape, out_valid_i && (record_kind_i == KindHeader),
    !found_i && !truncated_i)

  `BTLV_ASSERT_NOW(a_end_nomatch, out_valid_i && (record_kind_i == KindEnd) && !found_i,
    (value_len_i == 16'd0) && (value_offset_i == 16'd0))

endmodule

bind ber_tlv_tag_finder btlv_chk u_btlv_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .record_kind_i  (record_kind_o),
  .tag_i          (tag_o),
  .value_len_i    (value_len_o),
  .value_offset_i (value_offset_o),
  .tag_match_i    (tag_match_o),
  .found_i        (found_o),
  .truncated_i    (truncated_o),
  .last_of_run_i  (last_of_run_o)
);

// ===== sim/ber_tlv_tag_finder_tb.sv =====
// Self-checking testbench for the BER-TLV tag finder: directed buffers, then random ones.
// Depends on btlv_pkg and ber_tlv_tag_finder; expected records come from a built-in walker.
module ber_tlv_tag_finder_tb import btlv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 1_000_000;
  localparam int PhaseBytes   = 300;
  localparam int QuietBytes   = 180;
  localparam int DrainCycles  = 4;

  typedef enum logic [2:0] {
    WantTag0, WantTag1, WantLen0, WantLen81, WantLenHi, WantLenLo, SkipValue
  } walk_phase_e;

  typedef struct {
    logic [7:0] data;
    logic       lst;
    logic       typed;
    rec_t       closing;
  } dir_row_t;

  localparam rec_t EndMatchAtTwo = '{kind: KindEnd, tag: 16'h0000, value_len: 16'h0000,
                                     value_offset: 16'h0002, tag_match: 1'b0, found: 1'b1,
                                     truncated: 1'b0, last_of_run: 1'b1};
  localparam rec_t EndNone = '{kind: KindEnd, tag: 16'h0000, value_len: 16'h0000,
                               value_offset: 16'h0000, tag_match: 1'b0, found: 1'b0,
                               truncated: 1'b0, last_of_run: 1'b1};
  localparam rec_t EndCut = '{kind: KindEnd, tag: 16'h0000, value_len: 16'h0000,
                              value_offset: 16'h0000, tag_match: 1'b0, found: 1'b0,
                              truncated: 1'b1, last_of_run: 1'b1};
  localparam rec_t NoRec = '0;

  // Short buffers: zero tag and length, cut-off tags and lengths, long forms, big lengths
  dir_row_t dir_rows [0:24] = '{
    '{8'h00, 1'b0, 1'b0, NoRec}, '{8'h00, 1'b1, 1'b1, EndMatchAtTwo},
    '{8'h9f, 1'b1, 1'b1, EndCut},
    '{8'h5f, 1'b0, 1'b0, NoRec}, '{8'h2d, 1'b0, 1'b0, NoRec}, '{8'h82, 1'b0, 1'b0, NoRec},
    '{8'h00, 1'b0, 1'b0, NoRec}, '{8'h02, 1'b0, 1'b0, NoRec}, '{8'haa, 1'b0, 1'b0, NoRec},
    '{8'hbb, 1'b1, 1'b1, EndNone},
    '{8'h4f, 1'b0, 1'b0, NoRec}, '{8'h81, 1'b0, 1'b0, NoRec}, '{8'hff, 1'b0, 1'b0, NoRec},
    '{8'h01, 1'b0, 1'b0, NoRec}, '{8'h02, 1'b1, 1'b1, EndNone},
    '{8'hff, 1'b0, 1'b0, NoRec}, '{8'hff, 1'b0, 1'b0, NoRec}, '{8'h83, 1'b0, 1'b0, NoRec},
    '{8'h00, 1'b1, 1'b1, EndNone},
    '{8'h01, 1'b0, 1'b0, NoRec}, '{8'h81, 1'b1, 1'b1, EndCut},
    '{8'h02, 1'b0, 1'b0, NoRec}, '{8'h82, 1'b0, 1'b0, NoRec}, '{8'h01, 1'b1, 1'b1, EndCut},
    '{8'h03, 1'b1, 1'b1, EndCut}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        record_kind;
  logic [15:0] tag;
  logic [15:0] value_len;
  logic [15:0] value_offset;
  logic        tag_match;
  logic        found;
  logic        truncated;
  logic        last_of_run;

  // Walker state mirrored from the block
  walk_phase_e w_phase = WantTag0;
  logic [15:0] w_tag = '0, w_len = '0, w_skip = '0, w_offset = '0;
  logic        w_seen = 1'b0;
  logic [15:0] w_match_off = '0, w_match_len = '0;
  logic [15:0] target = '0;

  rec_t exp_records [$];
  int   err_count = 0;
  int   cycles = 0;
  int   bytes_sent = 0;
  int   idle_pct = 20;
  logic quiet = 1'b0;

  ber_tlv_tag_finder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .record_kind_o  (record_kind),
    .tag_o          (tag),
    .value_len_o    (value_len),
    .value_offset_o (value_offset),
    .tag_match_o    (tag_match),
    .found_o        (found),
    .truncated_o    (truncated),
    .last_of_run_o  (last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Advance the walker by one accepted byte and queue the records it yields
  task automatic walk_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input rec_t closing);
    rec_t        recs [2];
    int          n;
    logic        hdr_done;
    logic        hit;
    logic [15:0] voff;
    n = 0;
    hdr_done = 1'b0;
    case (w_phase)
      WantTag0: begin
        w_tag = {8'h00, b};
        w_phase = (b[4:0] == TagExtMask) ? WantTag1 : WantLen0;
      end
      WantTag1: begin
        w_tag = {w_tag[7:0], b};
        w_phase = WantLen0;
      end
      WantLen0: begin
        if (b == LenTwoByte) begin
          w_phase = WantLenHi;
        end else if (b == LenOneByte) begin
          w_phase = WantLen81;
        end else begin
          w_len = {8'h00, b};
          hdr_done = 1'b1;
        end
      end
      WantLen81: begin
        w_len = {8'h00, b};
        hdr_done = 1'b1;
      end
      WantLenHi: begin
        w_len = {b, 8'h00};
        w_phase = WantLenLo;
      end
      WantLenLo: begin
        w_len = w_len | {8'h00, b};
        hdr_done = 1'b1;
      end
      default: begin
        if (w_skip != 0) w_skip = w_skip - 1'b1;
        if (w_skip == 0) w_phase = WantTag0;
      end
    endcase

    if (hdr_done) begin
      voff = w_offset + 1'b1;
      hit = !w_seen && (w_tag == target);
      if (hit) begin
        w_seen = 1'b1;
        w_match_off = voff;
        w_match_len = w_len;
      end
      recs[n] = '{kind: KindHeader, tag: w_tag, value_len: w_len, value_offset: voff,
                  tag_match: hit, found: 1'b0, truncated: 1'b0, last_of_run: 1'b0};
      n++;
      w_skip = w_len;
      w_phase = (w_len == 0) ? WantTag0 : SkipValue;
    end

    w_offset = w_offset + 1'b1;

    if (lst) begin
      recs[n] = '{kind: KindEnd, tag: 16'h0000,
                  value_len: w_seen ? w_match_len : 16'h0000,
                  value_offset: w_seen ? w_match_off : 16'h0000,
                  tag_match: 1'b0, found: w_seen,
                  truncated: (w_phase >= WantTag1 && w_phase <= WantLenLo),
                  last_of_run: 1'b0};
      n++;
      w_phase = WantTag0;
      w_tag = '0;
      w_len = '0;
      w_skip = '0;
      w_offset = '0;
      w_seen = 1'b0;
      w_match_off = '0;
      w_match_len = '0;
    end

    if (n > 0) begin
      recs[n-1].last_of_run = 1'b1;
      if (typed) recs[n-1] = closing;
    end
    for (int i = 0; i < n; i++) exp_records.push_back(recs[i]);
  endtask

  // Entered and left at a falling edge; valid stays high between back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input rec_t closing);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    last_byte = lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_byte(b, lst, typed, closing);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (exp_records.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_target(input logic [15:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    target = v;
  endtask

  function automatic logic [15:0] random_tag();
    logic [7:0] hi, lo;
    hi = 8'($urandom);
    lo = 8'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      if (lo[4:0] == TagExtMask) lo[0] = 1'b0;
      return {8'h00, lo};
    end
    hi[4:0] = TagExtMask;
    return {hi, lo};
  endfunction

  // One buffer: mostly well-formed elements, some cut short, some plain noise
  task automatic send_buffer();
    logic [7:0]  buf_q [$];
    logic [15:0] tg;
    int          vlen, form, style;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 12)) buf_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        tg = ($urandom_range(0, 2) == 0) ? target : random_tag();
        if (tg[15:8] != 0) buf_q.push_back(tg[15:8]);
        buf_q.push_back(tg[7:0]);
        vlen = $urandom_range(0, 6);
        form = $urandom_range(0, 19);
        if (form < 12) begin
          buf_q.push_back(8'(vlen));
        end else if (form < 15) begin
          buf_q.push_back(LenOneByte);
          buf_q.push_back(8'(vlen));
        end else if (form < 18) begin
          buf_q.push_back(LenTwoByte);
          buf_q.push_back(8'h00);
          buf_q.push_back(8'(vlen));
        end else begin
          // first length byte that stands as its own value
          vlen = $urandom_range(128, 255);
          if (vlen == LenOneByte || vlen == LenTwoByte) vlen = 128;
          buf_q.push_back(8'(vlen));
        end
        repeat (vlen) buf_q.push_back(8'($urandom));
      end
      if (style == 1 && buf_q.size() > 1)
        repeat ($urandom_range(1, buf_q.size() - 1)) void'(buf_q.pop_back());
    end
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, NoRec);
  endtask

  // Result side: random stall bursts, none once the run goes quiet
  always begin
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_records.size() == 0) begin
        report_mismatch("record with nothing expected, tag", tag, 0);
      end else begin
        want = exp_records.pop_front();
        if (record_kind !== want.kind) report_mismatch("record_kind", record_kind, want.kind);
        if (tag !== want.tag) report_mismatch("tag", tag, want.tag);
        if (value_len !== want.value_len)
          report_mismatch("value_len", value_len, want.value_len);
        if (value_offset !== want.value_offset)
          report_mismatch("value_offset", value_offset, want.value_offset);
        if (tag_match !== want.tag_match)
          report_mismatch("tag_match", tag_match, want.tag_match);
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (truncated !== want.truncated)
          report_mismatch("truncated", truncated, want.truncated);
        if (last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", last_of_run, want.last_of_run);
      end
    end
  end

  initial begin
    logic [15:0] phase_targets [5];
    int          idle_levels [5];
    phase_targets = '{16'hffff, 16'h0000, random_tag(), random_tag(), random_tag()};
    idle_levels = '{30, 10, 0, 30, 50};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Target stays at its reset value for the directed buffers
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].closing);
    wait_drained();

    foreach (phase_targets[p]) begin
      write_target(phase_targets[p]);
      idle_pct = idle_levels[p];
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) send_buffer();
      wait_drained();
    end

    // Last part: no idling on either side
    quiet = 1'b1;
    bytes_sent = 0;
    while (bytes_sent < QuietBytes) send_buffer();
    wait_drained();
    repeat (8) @(negedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== ber_tlv_tag_finder.f =====
+incdir+hw/rtl
hw/rtl/btlv_pkg.sv
hw/rtl/btlv_parser.sv
hw/rtl/btlv_outq.sv
hw/rtl/ber_tlv_tag_finder.sv
hw/rtl/btlv_chk.sv
sim/ber_tlv_tag_finder_tb.sv
